@@ design/ght_pkg.sv @@
// Shared constants, operation codes and helper functions for the generational handle table.
// No dependencies; the top level refers to this package by scoped names.
`default_nettype none

package ght_pkg;

    localparam int TOKEN_W  = 32;
    localparam int GEN_W    = 32;
    localparam int HANDLE_W = 64;
    localparam int COUNT_W  = 9;
    localparam int OP_W     = 2;

    // Request operation codes carried in s_tuser.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
    localparam logic [OP_W-1:0] OP_RETIRE = 2'd2;

    // Generation after a retire: counts up and skips zero on wrap.
    function automatic logic [GEN_W-1:0] next_gen(input logic [GEN_W-1:0] gen);
        logic [GEN_W-1:0] inc;
        inc = gen + {{(GEN_W-1){1'b0}}, 1'b1};
        return (inc == '0) ? {{(GEN_W-1){1'b0}}, 1'b1} : inc;
    endfunction

endpackage

`default_nettype wire

@@ design/ght_ram.sv @@
// Simple dual-port synchronous RAM: one write port, one read port with registered data.
// Used for the slot table and the free-slot stack; no package dependency.
`default_nettype none

module ght_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read, so a stalled consumer sees stable data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ design/generational_handle_table.sv @@
// Generational handle table top level: request decode, read-modify-write control and result register.
// Depends on ght_pkg and instantiates ght_ram twice (slot table and free-slot stack).
//
// Usage:
// The request channel (s_*) carries one request per handshake: the operation in s_tuser
// (insert, find or retire) and the handle and entry token in s_tdata. The result channel
// (m_*) returns exactly one result per request, in order: the issued handle, the token
// found or retired, the active entry count, and a success flag in m_tuser.
// Each request passes through two states. In the accept cycle the slot table is read at the slot
// named by the handle and the free-slot stack is read at its top. In the execute state the
// registered read data is checked, the table and stack are written back and the result is
// loaded into the output register. The next request is taken in the cycle after that, so a
// new request is never taken before the last one has finished. Reads and writes never overlap
// on the same entry because a request is only accepted once the previous one has written back.
// A request is accepted even while a result still waits on m_*; its write-back then waits
// until the output register is free, and the read data is held meanwhile.
// Synchronous active-low reset empties the table: no slots in use, empty free stack, zero
// live entries, no pending result. The memories are not cleared; a slot is always written
// by an insert before a request can use what is read from it.

`default_nettype none

module generational_handle_table #(
    parameter int NUM_SLOTS = 256
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Request channel.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // [63:0] handle, [95:64] entry_token
    input  wire logic [1:0]   s_tuser,   // [1:0] op
    // Result channel.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [111:0] m_tdata,   // [63:0] handle_out, [95:64] entry_out,
                                         // [104:96] active_count, [111:105] zero
    output logic              m_tuser    // [0] ok
);

    localparam int SLOT_W  = $clog2(NUM_SLOTS);
    localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
    localparam int TOKEN_W = ght_pkg::TOKEN_W;
    localparam int GEN_W   = ght_pkg::GEN_W;
    localparam int TBL_W   = GEN_W + TOKEN_W;
    localparam int FS_W    = GEN_W + SLOT_W;

    // Two-state sequencer: take a request, then finish it.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // How an insert obtains its slot, decided at accept time.
    localparam logic [1:0] INS_NONE = 2'd0;
    localparam logic [1:0] INS_POP  = 2'd1;
    localparam logic [1:0] INS_NEW  = 2'd2;

    logic                state_reg, state_next;
    logic [1:0]          op_reg;
    logic                hvalid_reg;
    logic [GEN_W-1:0]    gen_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [TOKEN_W-1:0]  token_reg;
    logic [1:0]          ins_kind_reg;

    logic [CNT_W-1:0]    mark_reg, mark_next;
    logic [CNT_W-1:0]    depth_reg, depth_next;
    logic [CNT_W-1:0]    live_reg, live_next;

    logic                m_tvalid_reg;
    logic [63:0]         hout_reg, hout_next;
    logic [TOKEN_W-1:0]  eout_reg, eout_next;
    logic                ok_reg, ok_next;
    logic [ght_pkg::COUNT_W-1:0] cnt_reg;

    // Request decode.
    logic                accept;
    logic [31:0]         s_lo;
    logic [31:0]         s_slot_raw;
    logic [GEN_W-1:0]    s_gen;
    logic [TOKEN_W-1:0]  s_tok;
    logic                s_hvalid;
    logic [1:0]          s_ins_kind;
    logic [CNT_W-1:0]    depth_dec;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_lo       = s_tdata[31:0];
    assign s_gen      = s_tdata[63:32];
    assign s_tok      = s_tdata[95:64];
    assign s_slot_raw = s_lo - 32'd1;
    // A handle names a slot only if both parts are nonzero and the slot was ever taken.
    assign s_hvalid   = (s_lo != '0) && (s_gen != '0) && (s_slot_raw < 32'(mark_reg));
    assign depth_dec  = depth_reg - {{(CNT_W-1){1'b0}}, 1'b1};

    always_comb begin
        if (s_tok == '0) begin
            s_ins_kind = INS_NONE;
        end else if (depth_reg != '0) begin
            s_ins_kind = INS_POP;
        end else if (mark_reg < CNT_W'(NUM_SLOTS)) begin
            s_ins_kind = INS_NEW;
        end else begin
            s_ins_kind = INS_NONE;
        end
    end

    // Memories.
    logic                tbl_we;
    logic [SLOT_W-1:0]   tbl_waddr;
    logic [TBL_W-1:0]    tbl_wdata;
    logic [TBL_W-1:0]    tbl_rdata;
    logic                fs_we;
    logic [FS_W-1:0]     fs_wdata;
    logic [FS_W-1:0]     fs_rdata;

    // Slot table entry: generation in the upper half, token in the lower half.
    ght_ram #(.DEPTH(NUM_SLOTS), .WIDTH(TBL_W)) u_slot_table (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (tbl_waddr),
        .wr_data (tbl_wdata),
        .rd_en   (accept),
        .rd_addr (s_slot_raw[SLOT_W-1:0]),
        .rd_data (tbl_rdata)
    );

    // Free stack entry: the slot and the generation it will carry when reused.
    ght_ram #(.DEPTH(NUM_SLOTS), .WIDTH(FS_W)) u_free_stack (
        .aclk    (aclk),
        .wr_en   (fs_we),
        .wr_addr (depth_reg[SLOT_W-1:0]),
        .wr_data (fs_wdata),
        .rd_en   (accept),
        .rd_addr (depth_dec[SLOT_W-1:0]),
        .rd_data (fs_rdata)
    );

    // Finish stage: check read data, write back and form the result.
    logic                fire;
    logic [TOKEN_W-1:0]  tbl_tok;
    logic [GEN_W-1:0]    tbl_gen;
    logic [SLOT_W-1:0]   fs_slot;
    logic [GEN_W-1:0]    fs_gen;
    logic [GEN_W-1:0]    gen_adv;
    logic                gen_match;
    logic [31:0]         live_wide;

    assign fire      = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign tbl_tok   = tbl_rdata[TOKEN_W-1:0];
    assign tbl_gen   = tbl_rdata[TBL_W-1:TOKEN_W];
    assign fs_slot   = fs_rdata[SLOT_W-1:0];
    assign fs_gen    = fs_rdata[FS_W-1:SLOT_W];
    assign gen_adv   = ght_pkg::next_gen(gen_reg);
    assign gen_match = hvalid_reg && (tbl_gen == gen_reg);

    always_comb begin
        tbl_we     = 1'b0;
        tbl_waddr  = slot_reg;
        tbl_wdata  = {gen_adv, {TOKEN_W{1'b0}}};
        fs_we      = 1'b0;
        fs_wdata   = {gen_adv, slot_reg};
        mark_next  = mark_reg;
        depth_next = depth_reg;
        live_next  = live_reg;
        hout_next  = '0;
        eout_next  = '0;
        ok_next    = 1'b0;
        if (fire) begin
            unique case (op_reg)
                ght_pkg::OP_INSERT: begin
                    unique case (ins_kind_reg)
                        INS_POP: begin
                            tbl_we     = 1'b1;
                            tbl_waddr  = fs_slot;
                            tbl_wdata  = {fs_gen, token_reg};
                            depth_next = depth_dec;
                            live_next  = live_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                            hout_next  = {fs_gen, 32'(fs_slot) + 32'd1};
                            ok_next    = 1'b1;
                        end
                        INS_NEW: begin
                            tbl_we    = 1'b1;
                            tbl_waddr = mark_reg[SLOT_W-1:0];
                            tbl_wdata = {32'd1, token_reg};
                            mark_next = mark_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                            live_next = live_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                            hout_next = {32'd1, 32'(mark_reg) + 32'd1};
                            ok_next   = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                ght_pkg::OP_FIND: begin
                    if (gen_match) begin
                        eout_next = tbl_tok;
                        ok_next   = (tbl_tok != '0);
                    end
                end
                ght_pkg::OP_RETIRE: begin
                    if (gen_match && (tbl_tok != '0)) begin
                        tbl_we    = 1'b1;
                        eout_next = tbl_tok;
                        ok_next   = 1'b1;
                        if (depth_reg < CNT_W'(NUM_SLOTS)) begin
                            fs_we      = 1'b1;
                            depth_next = depth_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                        end
                        if (live_reg != '0) begin
                            live_next = live_reg - {{(CNT_W-1){1'b0}}, 1'b1};
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign live_wide = 32'(live_next);

    always_comb begin
        state_next = state_reg;
        if (accept) begin
            state_next = ST_EXEC;
        end else if (fire) begin
            state_next = ST_IDLE;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mark_reg     <= '0;
            depth_reg    <= '0;
            live_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mark_reg  <= mark_next;
            depth_reg <= depth_next;
            live_reg  <= live_next;
            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg       <= s_tuser;
            hvalid_reg   <= s_hvalid;
            gen_reg      <= s_gen;
            slot_reg     <= s_slot_raw[SLOT_W-1:0];
            token_reg    <= s_tok;
            ins_kind_reg <= s_ins_kind;
        end
        if (fire) begin
            hout_reg <= hout_next;
            eout_reg <= eout_next;
            ok_reg   <= ok_next;
            cnt_reg  <= live_wide[ght_pkg::COUNT_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, cnt_reg, eout_reg, hout_reg};
    assign m_tuser  = ok_reg;

    // Every slot ever taken is either live or waiting on the free stack.
    a_slot_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(depth_reg) + 32'(live_reg)) == 32'(mark_reg))
        else $error("free stack depth plus live count differs from slots in use");

    // The never-used slot mark never runs past the table size.
    a_mark_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        mark_reg <= CNT_W'(NUM_SLOTS))
        else $error("slot mark beyond table size");

    // An accepted request is finished before the next one is taken.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_EXEC) && !s_tready)
        else $error("request accepted while another is in flight");

    // A successful insert adds exactly one live entry.
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (op_reg == ght_pkg::OP_INSERT) && ok_next)
        |=> live_reg == $past(live_reg) + {{(CNT_W-1){1'b0}}, 1'b1})
        else $error("insert did not advance the live count");

    // A result is loaded only into a free or draining output register.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !fire)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire
